@@ rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Types and codes shared by the banker's safe-request guard.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int RESOURCES = 3;

    localparam logic [1:0] ACT_SET_AVAIL = 2'd0;
    localparam logic [1:0] ACT_SET_PROC  = 2'd1;
    localparam logic [1:0] ACT_REQUEST   = 2'd2;
    localparam logic [1:0] ACT_RELEASE   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVER_NEED  = 3'd1;
    localparam logic [2:0] ST_OVER_AVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_OVER_ALLOC = 3'd4;
    localparam logic [2:0] ST_OVER_MAX   = 3'd5;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] process;
        logic [7:0] amount_0;
        logic [7:0] amount_1;
        logic [7:0] amount_2;
        logic [7:0] limit_0;
        logic [7:0] limit_1;
        logic [7:0] limit_2;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] safe_order;
    } t_out;

endpackage

@@ rtl/bsr_table.sv @@
// ----------------------------------------------------------------------------
// bsr_table
// Per-process allocation/need memory with a registered read.
// Entries read as zero until first written.
// ----------------------------------------------------------------------------
module bsr_table #(
    parameter int DEPTH = 5,
    parameter int AW    = 3,
    parameter int W     = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ rtl/banker_safe_request.sv @@
// ----------------------------------------------------------------------------
// banker_safe_request
// Banker's algorithm guard: available vector in registers, per-process
// allocation and need in a synchronous memory, iterative safety pass.
// Set and release actions pass through the execute and done states; a request
// adds sweeps of the process memory, with a read state and an evaluate state for
// each process, plus a rollback state when no safe order is found.
// One item at a time; input reopens as the result loads into the output register.
// Reset clears the available vector and marks every process entry as zero.
// ----------------------------------------------------------------------------
module banker_safe_request #(
    parameter int PROCESSES  = 5,
    parameter int COUNT_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bsr_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bsr_pkg::t_out o_out
);

    localparam int CB = COUNT_BITS;
    localparam int NR = bsr_pkg::RESOURCES;
    localparam int AW = $clog2(PROCESSES);
    localparam int FW = $clog2(PROCESSES + 1);
    localparam int WW = CB + 4;
    localparam int EW = 2 * NR * CB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SEV  = 3'd3;
    localparam logic [2:0] S_ROLL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           r_state, n_state;
    bsr_pkg::t_in         r_item;
    logic [CB-1:0]        r_avail [NR];
    logic [CB-1:0]        n_avail [NR];
    logic [WW-1:0]        r_work  [NR];
    logic [WW-1:0]        n_work  [NR];
    logic [PROCESSES-1:0] r_done, n_done;
    logic [FW-1:0]        r_fin, n_fin;
    logic                 r_prog, n_prog;
    logic [AW-1:0]        r_idx, n_idx;
    logic [14:0]          r_order, n_order;
    logic [EW-1:0]        r_orig, n_orig;
    logic [2:0]           r_status, n_status;
    logic                 r_out_valid;
    bsr_pkg::t_out        r_out;

    logic [CB-1:0] w_amt [NR];
    logic [CB-1:0] w_lim [NR];
    logic [CB-1:0] w_a   [NR];
    logic [CB-1:0] w_n   [NR];
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_wdata, w_rd;
    logic          w_accept, w_in_range, w_fits;
    logic [CB:0]   w_sum;

    assign w_amt[0] = CB'({8'd0, r_item.amount_0});
    assign w_amt[1] = CB'({8'd0, r_item.amount_1});
    assign w_amt[2] = CB'({8'd0, r_item.amount_2});
    assign w_lim[0] = CB'({8'd0, r_item.limit_0});
    assign w_lim[1] = CB'({8'd0, r_item.limit_1});
    assign w_lim[2] = CB'({8'd0, r_item.limit_2});

    for (genvar g = 0; g < NR; g++) begin : g_split
        assign w_a[g] = w_rd[g*CB +: CB];
        assign w_n[g] = w_rd[(NR+g)*CB +: CB];
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_range = ({5'd0, r_item.process} < 8'(PROCESSES));
    assign w_raddr    = (r_state == S_IDLE) ? AW'(i_in.process) : r_idx;

    bsr_table #(.DEPTH(PROCESSES), .AW(AW), .W(EW)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (AW'(r_item.process)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_state  = r_state;
        n_avail  = r_avail;
        n_work   = r_work;
        n_done   = r_done;
        n_fin    = r_fin;
        n_prog   = r_prog;
        n_idx    = r_idx;
        n_order  = r_order;
        n_orig   = r_orig;
        n_status = r_status;
        w_we     = 1'b0;
        w_wdata  = w_rd;
        w_fits   = 1'b1;
        w_sum    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = bsr_pkg::ST_OK;
                n_order  = '0;
                n_state  = S_DONE;
                if (r_item.action == bsr_pkg::ACT_SET_AVAIL) begin
                    n_avail = w_amt;
                end else if (!w_in_range) begin
                    case (r_item.action)
                        bsr_pkg::ACT_SET_PROC: n_status = bsr_pkg::ST_OVER_MAX;
                        bsr_pkg::ACT_REQUEST:  n_status = bsr_pkg::ST_OVER_NEED;
                        default:               n_status = bsr_pkg::ST_OVER_ALLOC;
                    endcase
                end else if (r_item.action == bsr_pkg::ACT_SET_PROC) begin
                    for (int j = 0; j < NR; j++) begin
                        if (w_amt[j] > w_lim[j]) n_status = bsr_pkg::ST_OVER_MAX;
                        w_wdata[j*CB +: CB]      = w_amt[j];
                        w_wdata[(NR+j)*CB +: CB] = w_lim[j] - w_amt[j];
                    end
                    w_we = (n_status == bsr_pkg::ST_OK);
                end else if (r_item.action == bsr_pkg::ACT_REQUEST) begin
                    for (int j = 0; j < NR; j++) begin
                        if (w_amt[j] > w_n[j]) n_status = bsr_pkg::ST_OVER_NEED;
                    end
                    if (n_status == bsr_pkg::ST_OK) begin
                        for (int j = 0; j < NR; j++) begin
                            if (w_amt[j] > r_avail[j]) n_status = bsr_pkg::ST_OVER_AVAIL;
                        end
                    end
                    for (int j = 0; j < NR; j++) begin
                        w_wdata[j*CB +: CB]      = w_a[j] + w_amt[j];
                        w_wdata[(NR+j)*CB +: CB] = w_n[j] - w_amt[j];
                        n_work[j] = WW'(r_avail[j] - w_amt[j]);
                    end
                    if (n_status == bsr_pkg::ST_OK) begin
                        w_we   = 1'b1;
                        for (int j = 0; j < NR; j++) begin
                            n_avail[j] = r_avail[j] - w_amt[j];
                        end
                        n_orig  = w_rd;
                        n_done  = '0;
                        n_fin   = '0;
                        n_prog  = 1'b0;
                        n_idx   = '0;
                        n_state = S_SRD;
                    end
                end else begin
                    for (int j = 0; j < NR; j++) begin
                        if (w_amt[j] > w_a[j]) n_status = bsr_pkg::ST_OVER_ALLOC;
                        w_wdata[j*CB +: CB]      = w_a[j] - w_amt[j];
                        w_wdata[(NR+j)*CB +: CB] = w_n[j] + w_amt[j];
                    end
                    if (n_status == bsr_pkg::ST_OK) begin
                        w_we = 1'b1;
                        for (int j = 0; j < NR; j++) begin
                            w_sum = {1'b0, r_avail[j]} + {1'b0, w_amt[j]};
                            n_avail[j] = w_sum[CB] ? '1 : w_sum[CB-1:0];
                        end
                    end
                end
            end
            S_SRD: begin
                n_state = S_SEV;
            end
            S_SEV: begin
                for (int j = 0; j < NR; j++) begin
                    if (WW'(w_n[j]) > r_work[j]) w_fits = 1'b0;
                end
                if (!r_done[r_idx] && w_fits) begin
                    for (int j = 0; j < NR; j++) begin
                        n_work[j] = r_work[j] + WW'(w_a[j]);
                    end
                    n_done[r_idx] = 1'b1;
                    for (int s = 0; s < 5; s++) begin
                        if (r_fin == FW'(s)) n_order[s*3 +: 3] = 3'(r_idx);
                    end
                    n_fin  = r_fin + 1'b1;
                    n_prog = 1'b1;
                end
                if (n_fin == FW'(PROCESSES)) begin
                    n_status = bsr_pkg::ST_OK;
                    n_state  = S_DONE;
                end else if (r_idx == AW'(PROCESSES - 1)) begin
                    if (!n_prog) begin
                        n_state = S_ROLL;
                    end else begin
                        n_idx   = '0;
                        n_prog  = 1'b0;
                        n_state = S_SRD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_ROLL: begin
                w_we    = 1'b1;
                w_wdata = r_orig;
                for (int j = 0; j < NR; j++) begin
                    n_avail[j] = r_avail[j] + w_amt[j];
                end
                n_status = bsr_pkg::ST_UNSAFE;
                n_order  = '0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avail     <= '{default: '0};
            r_out_valid <= 1'b0;
            r_done      <= '0;
            r_fin       <= '0;
            r_prog      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            r_avail <= n_avail;
            r_done  <= n_done;
            r_fin   <= n_fin;
            r_prog  <= n_prog;
            r_idx   <= n_idx;
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
        r_work   <= n_work;
        r_order  <= n_order;
        r_orig   <= n_orig;
        r_status <= n_status;
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.status     <= r_status;
            r_out.safe_order <= r_order;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEV) |-> (32'(r_fin) == $countones(r_done)))
        else $error("finish count disagrees with done mask");

    a_roll_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROLL) |=> (r_state == S_DONE))
        else $error("rollback did not complete");

    a_unsafe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != bsr_pkg::ST_OK) |-> (r_out.safe_order == '0))
        else $error("order reported on refused request");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEV) |-> (32'(r_idx) < PROCESSES))
        else $error("scan index out of range");

endmodule

@@ dv/bsr_checker.sv @@
// ----------------------------------------------------------------------------
// bsr_checker
// Watches both channels of the banker's safe-request guard, predicts each
// result from its own copy of the resource tables and compares in order.
// ----------------------------------------------------------------------------
module bsr_checker #(
    parameter int PROCESSES  = 5,
    parameter int COUNT_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  bsr_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  bsr_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending
);

    localparam int CMAX = (1 << COUNT_BITS) - 1;
    localparam int NR   = bsr_pkg::RESOURCES;

    int             free_units [NR];
    int             held_units [PROCESSES][NR];
    int             need_units [PROCESSES][NR];
    bsr_pkg::t_out  expected_q [$];

    assign o_pending = expected_q.size();

    function automatic bit find_safe_order(output logic [14:0] order);
        int  work [NR];
        bit  done [PROCESSES];
        int  finished;
        bit  progress;
        bit  fits;
        order    = '0;
        finished = 0;
        for (int j = 0; j < NR; j++) work[j] = free_units[j];
        for (int i = 0; i < PROCESSES; i++) done[i] = 0;
        while (finished < PROCESSES) begin
            progress = 0;
            for (int i = 0; i < PROCESSES; i++) begin
                if (!done[i]) begin
                    fits = 1;
                    for (int j = 0; j < NR; j++)
                        if (need_units[i][j] > work[j]) fits = 0;
                    if (fits) begin
                        for (int j = 0; j < NR; j++) work[j] += held_units[i][j];
                        done[i] = 1;
                        if (finished < 5) order[3*finished +: 3] = i[2:0];
                        finished++;
                        progress = 1;
                    end
                end
            end
            if (!progress) return 0;
        end
        return 1;
    endfunction

    function automatic bsr_pkg::t_out apply_action(bsr_pkg::t_in it);
        bsr_pkg::t_out r;
        int   amt [NR];
        int   lim [NR];
        int   p;
        logic [14:0] order;
        r   = '0;
        p   = it.process;
        amt = '{it.amount_0 & CMAX, it.amount_1 & CMAX, it.amount_2 & CMAX};
        lim = '{it.limit_0 & CMAX, it.limit_1 & CMAX, it.limit_2 & CMAX};
        r.status = bsr_pkg::ST_OK;
        if (it.action == bsr_pkg::ACT_SET_AVAIL) begin
            for (int j = 0; j < NR; j++) free_units[j] = amt[j];
        end else if (p >= PROCESSES) begin
            r.status = (it.action == bsr_pkg::ACT_SET_PROC) ? bsr_pkg::ST_OVER_MAX :
                       (it.action == bsr_pkg::ACT_REQUEST) ? bsr_pkg::ST_OVER_NEED :
                                                             bsr_pkg::ST_OVER_ALLOC;
        end else if (it.action == bsr_pkg::ACT_SET_PROC) begin
            for (int j = 0; j < NR; j++)
                if (amt[j] > lim[j]) r.status = bsr_pkg::ST_OVER_MAX;
            if (r.status == bsr_pkg::ST_OK)
                for (int j = 0; j < NR; j++) begin
                    held_units[p][j] = amt[j];
                    need_units[p][j] = lim[j] - amt[j];
                end
        end else if (it.action == bsr_pkg::ACT_REQUEST) begin
            for (int j = 0; j < NR; j++)
                if (amt[j] > need_units[p][j]) r.status = bsr_pkg::ST_OVER_NEED;
            if (r.status == bsr_pkg::ST_OK)
                for (int j = 0; j < NR; j++)
                    if (amt[j] > free_units[j]) r.status = bsr_pkg::ST_OVER_AVAIL;
            if (r.status == bsr_pkg::ST_OK) begin
                for (int j = 0; j < NR; j++) begin
                    free_units[j]    -= amt[j];
                    held_units[p][j] += amt[j];
                    need_units[p][j] -= amt[j];
                end
                if (find_safe_order(order)) begin
                    r.safe_order = order;
                end else begin
                    for (int j = 0; j < NR; j++) begin
                        free_units[j]    += amt[j];
                        held_units[p][j] -= amt[j];
                        need_units[p][j] += amt[j];
                    end
                    r.status = bsr_pkg::ST_UNSAFE;
                end
            end
        end else begin
            for (int j = 0; j < NR; j++)
                if (amt[j] > held_units[p][j]) r.status = bsr_pkg::ST_OVER_ALLOC;
            if (r.status == bsr_pkg::ST_OK)
                for (int j = 0; j < NR; j++) begin
                    held_units[p][j] -= amt[j];
                    need_units[p][j] += amt[j];
                    free_units[j] = (free_units[j] + amt[j] > CMAX) ? CMAX
                                                                   : free_units[j] + amt[j];
                end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        bsr_pkg::t_out want;
        if (!i_rst_n) begin
            for (int j = 0; j < NR; j++) free_units[j] = 0;
            for (int i = 0; i < PROCESSES; i++)
                for (int j = 0; j < NR; j++) begin
                    held_units[i][j] = 0;
                    need_units[i][j] = 0;
                end
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected transfer: status %0d order %0h",
                           i_out.status, i_out.safe_order);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, i_out.status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_out.safe_order !== want.safe_order) begin
                        $error("safe_order: expected %0h actual %0h",
                               want.safe_order, i_out.safe_order);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(apply_action(i_in));
        end
    end
endmodule

@@ dv/tb_banker_safe_request.sv @@
// ----------------------------------------------------------------------------
// tb_banker_safe_request
// Drives directed and random resource actions into the banker's guard with
// random idling on both channels and a long output hold-off; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_banker_safe_request;

    localparam int PROCS     = 5;
    localparam int WDOG_MAX  = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_stall;
    bsr_pkg::t_in  in_item;
    logic          out_valid;
    logic          out_stall;
    bsr_pkg::t_out out_item;
    int            fail_count;
    int            pending;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_off;
    int            quiet_cycles;

    banker_safe_request #(.PROCESSES(PROCS), .COUNT_BITS(8)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item)
    );

    bsr_checker #(.PROCESSES(PROCS), .COUNT_BITS(8)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(negedge i_clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(bsr_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic bsr_pkg::t_in make_item(logic [1:0] act, logic [2:0] p,
                                      logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                      logic [7:0] l0, logic [7:0] l1, logic [7:0] l2);
        bsr_pkg::t_in it;
        it.action = act;   it.process = p;
        it.amount_0 = a0;  it.amount_1 = a1;  it.amount_2 = a2;
        it.limit_0 = l0;   it.limit_1 = l1;   it.limit_2 = l2;
        return it;
    endfunction

    function automatic logic [7:0] rand_count();
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: return ($urandom_range(1)) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(6));
        endcase
    endfunction

    // Mostly requests and releases with small counts, plus set-up actions; some raw noise.
    function automatic bsr_pkg::t_in random_item();
        bsr_pkg::t_in it;
        logic [63:0]  raw;
        logic [7:0]   l0, l1, l2;
        int  r;
        raw = {$urandom, $urandom};
        it  = raw[$bits(bsr_pkg::t_in)-1:0];
        r   = $urandom_range(99);
        l0 = rand_count(); l1 = rand_count(); l2 = rand_count();
        if (r < 10) begin
            it.action = bsr_pkg::ACT_SET_AVAIL;
            it.amount_0 = 8'($urandom_range(12)); it.amount_1 = 8'($urandom_range(12));
            it.amount_2 = 8'($urandom_range(12));
        end else if (r < 30) begin
            it.action  = bsr_pkg::ACT_SET_PROC;
            it.process = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                                   : 3'($urandom_range(4));
            it.limit_0 = l0; it.limit_1 = l1; it.limit_2 = l2;
            it.amount_0 = ($urandom_range(9) == 0) ? rand_count() : 8'($urandom_range(l0));
            it.amount_1 = ($urandom_range(9) == 0) ? rand_count() : 8'($urandom_range(l1));
            it.amount_2 = ($urandom_range(9) == 0) ? rand_count() : 8'($urandom_range(l2));
        end else if (r < 90) begin
            it.action  = ($urandom_range(2) == 0) ? bsr_pkg::ACT_RELEASE
                                                  : bsr_pkg::ACT_REQUEST;
            it.process = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                                   : 3'($urandom_range(4));
            it.amount_0 = 8'($urandom_range(3)); it.amount_1 = 8'($urandom_range(3));
            it.amount_2 = 8'($urandom_range(3));
        end
        return it;
    endfunction

    initial begin
        bsr_pkg::t_in dir [$];
        int  n;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        hold_off = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 79;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_SET_AVAIL, 0, 8'd10, 8'd5, 8'd7,
                                8'hFF, 8'hFF, 8'hFF));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd0, 0, 1, 0, 7, 5, 3));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd1, 2, 0, 0, 3, 2, 2));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd2, 3, 0, 2, 9, 0, 2));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd3, 2, 1, 1, 2, 2, 2));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd4, 0, 0, 2, 4, 3, 3));
        dir.push_back(make_item(bsr_pkg::ACT_SET_AVAIL, 0, 3, 3, 2, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd1, 1, 0, 2, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd4, 3, 3, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd0, 0, 2, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd0, 8'hFF, 0, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_RELEASE, 3'd1, 8'hFF, 0, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_RELEASE, 3'd2, 3, 0, 2, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_SET_AVAIL, 0, 8'hFE, 8'hFF, 8'hFF, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_RELEASE, 3'd3, 2, 1, 1, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd1, 8'hFF, 0, 0, 8'hFE, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd1, 8'hFF, 8'hFF, 8'hFF,
                                8'hFF, 8'hFF, 8'hFF));
        dir.push_back(make_item(bsr_pkg::ACT_SET_PROC, 3'd5, 0, 0, 0, 1, 1, 1));
        dir.push_back(make_item(bsr_pkg::ACT_REQUEST, 3'd6, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_RELEASE, 3'd7, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_item(bsr_pkg::ACT_SET_AVAIL, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir[k]) send_item(dir[k]);

        for (n = 0; n < 1850; n++) begin
            if (n == 300) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 620) begin
                send_idle_pct = 79;
                recv_idle_pct = 19;
            end
            if (n == 1240) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ banker_safe_request.f @@
rtl/bsr_pkg.sv
rtl/bsr_table.sv
rtl/banker_safe_request.sv
dv/bsr_checker.sv
dv/tb_banker_safe_request.sv
